FILE: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the epoch seconds to calendar converter:
// division selects, divisors, scaled reciprocals and the month start table.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Division select: one code per constant division in the sequence
  typedef logic [2:0] esc_sel_t;

  localparam esc_sel_t DIV_DAY    = 3'd0;  // seconds / 86400
  localparam esc_sel_t DIV_HOUR   = 3'd1;  // seconds of day / 3600
  localparam esc_sel_t DIV_MIN    = 3'd2;  // seconds of hour / 60
  localparam esc_sel_t DIV_WDAY   = 3'd3;  // (days + 4) / 7
  localparam esc_sel_t DIV_PERIOD = 3'd4;  // days since 1968 / 1461
  localparam esc_sel_t DIV_YEAR   = 3'd5;  // (days - leap days) / 365

  localparam int DIVISOR_W = 17;
  localparam int MAGIC_W   = 26;

  localparam logic [DIVISOR_W-1:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [DIVISOR_W-1:0] SECS_PER_HOUR   = 17'd3600;
  localparam logic [DIVISOR_W-1:0] SECS_PER_MIN    = 17'd60;
  localparam logic [DIVISOR_W-1:0] DAYS_PER_WEEK   = 17'd7;
  localparam logic [DIVISOR_W-1:0] DAYS_PER_PERIOD = 17'd1461;  // (4 * 365) + 1
  localparam logic [DIVISOR_W-1:0] DAYS_PER_YEAR   = 17'd365;

  // Scaled reciprocals, rounded up; exact for every dividend the block sees
  localparam logic [MAGIC_W-1:0] MAGIC_DAY    = 26'd50903317;  // 2^35 / 675, secs >> 7
  localparam logic [MAGIC_W-1:0] MAGIC_HOUR   = 26'd149131;    // 2^29 / 3600
  localparam logic [MAGIC_W-1:0] MAGIC_MIN    = 26'd4370;      // 2^18 / 60
  localparam logic [MAGIC_W-1:0] MAGIC_WDAY   = 26'd74899;     // 2^19 / 7
  localparam logic [MAGIC_W-1:0] MAGIC_PERIOD = 26'd91868;     // 2^27 / 1461
  localparam logic [MAGIC_W-1:0] MAGIC_YEAR   = 26'd91930;     // 2^25 / 365

  localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;          // 365 + 366
  localparam logic [15:0] EPOCH_WEEKDAY     = 16'd4;            // Thursday
  localparam logic [10:0] DAYS_TO_MARCH     = 11'd60;           // 31 + 29
  localparam logic [10:0] DAYS_LEAP_YEAR    = 11'd365;
  localparam logic [11:0] BASE_YEAR         = 12'd1968;

  // Day of year at which each month starts in a common year
  localparam logic [8:0] MONTH_START [0:11] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Control word from the sequencer to the datapath
  typedef struct packed {
    logic     capture;  // latch the input word
    logic     load;     // load the dividend for sel
    logic     mul;      // multiply the dividend by the reciprocal for sel
    logic     quo;      // take the quotient and its product with the divisor
    logic     save;     // store quotient and remainder for sel
    logic     fin;      // build the result word
    esc_sel_t sel;
  } esc_cmd_t;

  // Divisor of each division
  function automatic logic [DIVISOR_W-1:0] esc_divisor(input esc_sel_t sel);
    logic [DIVISOR_W-1:0] d;
    unique case (sel)
      DIV_DAY:    d = SECS_PER_DAY;
      DIV_HOUR:   d = SECS_PER_HOUR;
      DIV_MIN:    d = SECS_PER_MIN;
      DIV_WDAY:   d = DAYS_PER_WEEK;
      DIV_PERIOD: d = DAYS_PER_PERIOD;
      DIV_YEAR:   d = DAYS_PER_YEAR;
      default:    d = SECS_PER_DAY;
    endcase
    return d;
  endfunction

  // Scaled reciprocal of each division
  function automatic logic [MAGIC_W-1:0] esc_magic(input esc_sel_t sel);
    logic [MAGIC_W-1:0] m;
    unique case (sel)
      DIV_DAY:    m = MAGIC_DAY;
      DIV_HOUR:   m = MAGIC_HOUR;
      DIV_MIN:    m = MAGIC_MIN;
      DIV_WDAY:   m = MAGIC_WDAY;
      DIV_PERIOD: m = MAGIC_PERIOD;
      DIV_YEAR:   m = MAGIC_YEAR;
      default:    m = MAGIC_DAY;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, day of month, month (1-12), year, weekday (Sunday 0) and
// day of year. Every fourth year is a leap year, so dates are exact through
// 2099 and lag the Gregorian calendar by a day from 2100-03-01 on.
// ----------------------------------------------------------------------------
// One word in, one word out. A conversion runs six constant divisions in
// turn on one shared divider (by 86400, 3600, 60, 7, 1461 and 365) by
// reciprocal multiplication, each in the steps load the dividend, multiply
// by the scaled reciprocal, take the quotient and its product with the
// divisor and subtract for the remainder, followed by the month lookup and
// the result word. in_tready is high only while the sequencer is idle, so
// words are taken one at a time: a new word is not accepted until the last
// one is through. The result waits in an output register; a result the sink
// has not taken by the time the next one is ready holds the sequencer in its
// final step until it is taken.
module epoch_seconds_to_calendar_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
  // [25:22] month, [37:26] year, [40:38] weekday, [49:41] day_of_year,
  // [55:50] zero
  output logic [55:0] out_tdata
);
  import esc_pkg::*;

  esc_cmd_t cmd;

  // Sequencer
  esc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Divider and result registers
  esc_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_secs  (in_tdata),
    .out_word (out_tdata)
  );

endmodule

FILE: rtl/esc_dp.sv
// ----------------------------------------------------------------------------
// esc_dp
// Datapath: one shared divider by constants using reciprocal multiplication,
// the partial result registers, the month lookup and the result word register.
// ----------------------------------------------------------------------------
module esc_dp (
  input  logic              clk,
  input  esc_pkg::esc_cmd_t cmd,
  input  logic [31:0]       in_secs,
  output logic [55:0]       out_word   // see top level for the field layout
);
  import esc_pkg::*;

  // Divider state
  logic [31:0] x_r, x_nxt;        // dividend
  logic [50:0] prod_r, prod_nxt;  // dividend times scaled reciprocal
  logic [15:0] q_r, q_nxt;        // quotient
  logic [31:0] qd_r, qd_nxt;      // quotient times divisor
  logic [31:0] rem;

  // Partial results
  logic [31:0]  secs_r;
  logic [15:0]  days_r;
  logic [16:0]  sod_r;
  logic [11:0]  soh_r;
  logic [4:0]   hour_r;
  logic [5:0]   minute_r;
  logic [5:0]   second_r;
  logic [2:0]   weekday_r;
  logic [5:0]   periods_r;
  logic [10:0]  prem_r;
  logic [7:0]   years_r;
  logic [8:0]   doy_r;
  logic [55:0]  out_r;

  // Day count rebased to 1968 and leap day bookkeeping
  logic [15:0] d1968;
  logic        past_feb;
  logic        leap_used;
  logic [5:0]  periods_adj;
  logic [15:0] year_days;

  assign d1968       = days_r + DAYS_1968_TO_1970;
  assign past_feb    = (prem_r >= DAYS_TO_MARCH);
  assign leap_used   = past_feb && (prem_r <= DAYS_LEAP_YEAR);
  assign periods_adj = periods_r + {5'd0, past_feb};
  assign year_days   = d1968 - {10'd0, periods_adj};

  // Seconds drop the factor 128 of 86400 before the multiply
  logic [24:0] mul_a;

  assign mul_a = (cmd.sel == DIV_DAY) ? x_r[31:7] : x_r[24:0];

  // Quotient: the product shifted down by the reciprocal's scale
  logic [15:0] q_slice;

  always_comb begin
    unique case (cmd.sel)
      DIV_DAY:    q_slice = prod_r[50:35];
      DIV_HOUR:   q_slice = prod_r[44:29];
      DIV_MIN:    q_slice = prod_r[33:18];
      DIV_WDAY:   q_slice = prod_r[34:19];
      DIV_PERIOD: q_slice = prod_r[42:27];
      DIV_YEAR:   q_slice = prod_r[40:25];
      default:    q_slice = prod_r[50:35];
    endcase
  end

  // Load the dividend, multiply, then take quotient and quotient times divisor
  always_comb begin
    x_nxt    = x_r;
    prod_nxt = prod_r;
    q_nxt    = q_r;
    qd_nxt   = qd_r;
    if (cmd.load) begin
      unique case (cmd.sel)
        DIV_DAY:    x_nxt = secs_r;
        DIV_HOUR:   x_nxt = {15'd0, sod_r};
        DIV_MIN:    x_nxt = {20'd0, soh_r};
        DIV_WDAY:   x_nxt = {16'd0, days_r + EPOCH_WEEKDAY};
        DIV_PERIOD: x_nxt = {16'd0, d1968};
        DIV_YEAR:   x_nxt = {16'd0, year_days};
        default:    x_nxt = secs_r;
      endcase
    end
    if (cmd.mul) begin
      // 25 x 26 bit product
      prod_nxt = 51'(mul_a) * 51'(esc_magic(cmd.sel));
    end
    if (cmd.quo) begin
      q_nxt  = q_slice;
      qd_nxt = 32'(q_slice) * 32'(esc_divisor(cmd.sel));
    end
  end

  assign rem = x_r - qd_r;

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
    qd_r   <= qd_nxt;
  end

  // Hold the input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      secs_r <= in_secs;
    end
  end

  // Store quotient and remainder of the finished division
  always_ff @(posedge clk) begin
    if (cmd.save) begin
      unique case (cmd.sel)
        DIV_DAY: begin
          days_r <= q_r;
          sod_r  <= rem[16:0];
        end
        DIV_HOUR: begin
          hour_r <= q_r[4:0];
          soh_r  <= rem[11:0];
        end
        DIV_MIN: begin
          minute_r <= q_r[5:0];
          second_r <= rem[5:0];
        end
        DIV_WDAY: begin
          weekday_r <= rem[2:0];
        end
        DIV_PERIOD: begin
          periods_r <= q_r[5:0];
          prem_r    <= rem[10:0];
        end
        DIV_YEAR: begin
          years_r <= q_r[7:0];
          doy_r   <= rem[8:0] + {8'd0, leap_used};
        end
        default: begin
          days_r <= days_r;
        end
      endcase
    end
  end

  // Find the month: the last month whose start is not past the day of year
  logic       leap;
  logic [3:0] month;
  logic [8:0] mstart;
  logic [8:0] mday_full;
  logic [11:0] year_full;

  always_comb begin
    logic [8:0] ms;
    leap   = (years_r[1:0] == 2'b00);
    month  = 4'd1;
    mstart = '0;
    for (int m = 2; m <= 12; m++) begin
      ms = MONTH_START[m-1] + {8'd0, (m > 2) && leap};
      if (doy_r >= ms) begin
        month  = 4'(m);
        mstart = ms;
      end
    end
    mday_full = doy_r - mstart + 9'd1;
    year_full = BASE_YEAR + {4'd0, years_r};
  end

  // Build the result word
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r <= {6'd0, doy_r, weekday_r, year_full, month, mday_full[4:0],
                hour_r, minute_r, second_r};
    end
  end

  assign out_word = out_r;

endmodule

FILE: rtl/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: runs the six constant divisions one after another, then hands
// the finished result to the output register and tracks its valid flag.
// ----------------------------------------------------------------------------
module esc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output esc_pkg::esc_cmd_t cmd
);
  import esc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_QUO  = 3'd3;
  localparam logic [2:0] S_SAVE = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  esc_sel_t          sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Advance through the division sequence
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.sel       = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          sel_nxt     = DIV_DAY;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_QUO;
      end
      S_QUO: begin
        cmd.quo   = 1'b1;
        state_nxt = S_SAVE;
      end
      S_SAVE: begin
        cmd.save = 1'b1;
        if (sel_r == DIV_YEAR) begin
          state_nxt = S_FIN;
        end else begin
          sel_nxt   = sel_r + 3'd1;
          state_nxt = S_LOAD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= DIV_DAY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
